>>> design/lz77hc_pkg.sv
// Shared types and constants for the LZ77 history copy core.
package lz77hc_pkg;

   localparam int BYTE_W = 8;
   localparam int DIST_W = 14;
   localparam int LEN_W = 7;
   localparam int KIND_W = 2;
   localparam int WSIZE_W = 14;

   localparam logic [KIND_W-1:0] KIND_LITERAL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COPY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

   localparam logic [WSIZE_W-1:0] WSIZE_RESET = 14'd8192;

   // Register index of the window limit, taken from paddr[2]
   localparam logic REG_WINDOW_SIZE = 1'b0;

   // Token queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef enum logic [1:0] {
      OP_LITERAL,
      OP_COPY,
      OP_RESTART
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   literal;
      logic [DIST_W-1:0]   distance;
      logic [LEN_W-1:0]    run_length;
      logic                bad;
   } token_type;

   typedef enum logic {
      BK_IDLE,
      BK_COPY
   } back_state_type;

endpackage

>>> design/lz77hc_front.sv
// Front end: accepts tokens, classifies them, drops no-ops and checks copy distance.
module lz77hc_front #(
   parameter int WINDOW_DEPTH = 8192,
   parameter int MAX_RUN = 64
) (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,
   input  logic [lz77hc_pkg::KIND_W-1:0]   req_tuser,
   input  logic [lz77hc_pkg::WSIZE_W-1:0]  win_limit,
   input  logic                            q_full,
   output logic                            q_push,
   output lz77hc_pkg::token_type           q_token
);

   localparam int DW = $clog2(WINDOW_DEPTH + 1);
   localparam int CW = (DW > lz77hc_pkg::WSIZE_W) ? DW : lz77hc_pkg::WSIZE_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

   logic [lz77hc_pkg::BYTE_W-1:0] literal;
   logic [lz77hc_pkg::DIST_W-1:0] distance;
   logic [lz77hc_pkg::LEN_W-1:0]  run_length;
   logic [lz77hc_pkg::LEN_W-1:0]  run_clamped;
   logic [CW-1:0]                 reach;
   logic [CW-1:0]                 dist_c;
   logic                          keep;

   assign literal    = req_tdata[7:0];
   assign distance   = req_tdata[21:8];
   assign run_length = req_tdata[28:22];

   assign req_tready = !q_full;

   always_comb begin
      reach = (CW'(win_limit) < DEPTH_C) ? CW'(win_limit) : DEPTH_C;
      dist_c = CW'(distance);
      run_clamped = (run_length > lz77hc_pkg::LEN_W'(MAX_RUN)) ?
                    lz77hc_pkg::LEN_W'(MAX_RUN) : run_length;

      q_token.literal    = literal;
      q_token.distance   = distance;
      q_token.run_length = run_clamped;
      q_token.bad        = (distance == '0) || (dist_c > reach);
      q_token.op         = lz77hc_pkg::OP_LITERAL;
      keep = 1'b0;
      unique case (req_tuser)
         lz77hc_pkg::KIND_LITERAL: begin
            q_token.op = lz77hc_pkg::OP_LITERAL;
            keep = 1'b1;
         end
         lz77hc_pkg::KIND_COPY: begin
            q_token.op = lz77hc_pkg::OP_COPY;
            // a zero-length copy produces nothing: drop it here
            keep = (run_clamped != '0);
         end
         lz77hc_pkg::KIND_RESTART: begin
            q_token.op = lz77hc_pkg::OP_RESTART;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = req_tvalid && !q_full && keep;

endmodule

>>> design/lz77hc_queue.sv
// Short token queue between front and back end.
module lz77hc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lz77hc_pkg::token_type  push_token,
   input  logic                   pop,
   output logic                   full,
   output logic                   not_empty,
   output lz77hc_pkg::token_type  head
);

   lz77hc_pkg::token_type entry_ff [lz77hc_pkg::QUEUE_DEPTH];

   logic [lz77hc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lz77hc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lz77hc_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign full      = (count_ff == lz77hc_pkg::QCNT_W'(lz77hc_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

>>> design/lz77hc_back.sv
// Back end: history memory, copy sequencer and output register.
module lz77hc_back #(
   parameter int WINDOW_DEPTH = 8192
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_not_empty,
   input  lz77hc_pkg::token_type           q_head,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lz77hc_pkg::BYTE_W-1:0]   rsp_byte,
   output logic                            rsp_last,
   output logic                            rsp_bad
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int FW = AW + 1;
   localparam int CW = (FW > lz77hc_pkg::DIST_W) ? FW : lz77hc_pkg::DIST_W;
   localparam logic [FW-1:0] DEPTH_F = FW'(WINDOW_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);

   logic [lz77hc_pkg::BYTE_W-1:0] history [WINDOW_DEPTH];

   lz77hc_pkg::back_state_type state_ff, state_in;

   logic [AW-1:0]                 wp_ff, wp_in, wp_inc;
   logic [FW-1:0]                 filled_ff, filled_in, filled_inc;
   logic [lz77hc_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [lz77hc_pkg::LEN_W-1:0]  rem_ff, rem_in;
   logic                          bad_ff, bad_in;
   logic                          src_ok_ff, src_ok_in;
   logic                          fwd_ff, fwd_in;
   logic [lz77hc_pkg::BYTE_W-1:0] fwd_byte_ff, fwd_byte_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lz77hc_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_bad_ff, rsp_bad_in;

   logic                          mem_we;
   logic [AW-1:0]                 mem_wa;
   logic [lz77hc_pkg::BYTE_W-1:0] mem_wd;
   logic                          mem_re;
   logic [AW-1:0]                 mem_ra;
   logic [lz77hc_pkg::BYTE_W-1:0] mem_q_ff;

   logic                          out_free;
   logic [AW-1:0]                 src_wp;
   logic [FW-1:0]                 src_filled;
   logic [lz77hc_pkg::DIST_W-1:0] src_dist;
   logic                          src_bad;
   logic [CW-1:0]                 dist_c;
   logic [FW-1:0]                 diff;
   logic [FW-1:0]                 diff_wrap;
   logic [lz77hc_pkg::BYTE_W-1:0] copy_byte;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign wp_inc     = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
   assign filled_inc = (filled_ff == DEPTH_F) ? filled_ff : filled_ff + 1'b1;
   assign copy_byte  = !src_ok_ff ? '0 : (fwd_ff ? fwd_byte_ff : mem_q_ff);

   // Source address of the next copy byte: taken from the current write point
   // when a copy starts, from the advanced one while it runs.
   always_comb begin
      if (state_ff == lz77hc_pkg::BK_IDLE) begin
         src_wp     = wp_ff;
         src_filled = filled_ff;
         src_dist   = q_head.distance;
         src_bad    = q_head.bad;
      end else begin
         src_wp     = wp_inc;
         src_filled = filled_inc;
         src_dist   = dist_ff;
         src_bad    = bad_ff;
      end
      dist_c    = CW'(src_dist);
      diff      = {1'b0, src_wp} - dist_c[FW-1:0];
      diff_wrap = diff + DEPTH_F;
      mem_ra    = diff[FW-1] ? diff_wrap[AW-1:0] : diff[AW-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      filled_in    = filled_ff;
      dist_in      = dist_ff;
      rem_in       = rem_ff;
      bad_in       = bad_ff;
      src_ok_in    = src_ok_ff;
      fwd_in       = fwd_ff;
      fwd_byte_in  = fwd_byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      mem_we       = 1'b0;
      mem_wa       = wp_ff;
      mem_wd       = q_head.literal;
      mem_re       = 1'b0;
      q_pop        = 1'b0;

      unique case (state_ff)
         lz77hc_pkg::BK_IDLE: begin
            if (q_not_empty) begin
               unique case (q_head.op)
                  lz77hc_pkg::OP_LITERAL: begin
                     if (out_free) begin
                        mem_we       = 1'b1;
                        mem_wd       = q_head.literal;
                        wp_in        = wp_inc;
                        filled_in    = filled_inc;
                        rsp_valid_in = 1'b1;
                        rsp_byte_in  = q_head.literal;
                        rsp_last_in  = 1'b1;
                        rsp_bad_in   = 1'b0;
                        q_pop        = 1'b1;
                     end
                  end
                  lz77hc_pkg::OP_COPY: begin
                     // issue the read of the first byte
                     dist_in   = q_head.distance;
                     rem_in    = q_head.run_length;
                     bad_in    = q_head.bad;
                     mem_re    = 1'b1;
                     src_ok_in = !src_bad && (dist_c <= CW'(src_filled));
                     fwd_in    = 1'b0;
                     q_pop     = 1'b1;
                     state_in  = lz77hc_pkg::BK_COPY;
                  end
                  lz77hc_pkg::OP_RESTART: begin
                     wp_in     = '0;
                     filled_in = '0;
                     q_pop     = 1'b1;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         lz77hc_pkg::BK_COPY: begin
            if (out_free) begin
               mem_we       = 1'b1;
               mem_wd       = copy_byte;
               wp_in        = wp_inc;
               filled_in    = filled_inc;
               rem_in       = rem_ff - 1'b1;
               rsp_valid_in = 1'b1;
               rsp_byte_in  = copy_byte;
               rsp_last_in  = (rem_ff == lz77hc_pkg::LEN_W'(1));
               rsp_bad_in   = bad_ff;
               if (rem_ff == lz77hc_pkg::LEN_W'(1)) begin
                  state_in = lz77hc_pkg::BK_IDLE;
               end else begin
                  // read the next byte; forward when it is the one written now
                  mem_re      = 1'b1;
                  src_ok_in   = !src_bad && (dist_c <= CW'(src_filled));
                  fwd_in      = (mem_ra == wp_ff);
                  fwd_byte_in = copy_byte;
               end
            end
         end
         default: begin
            state_in = lz77hc_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lz77hc_pkg::BK_IDLE;
         wp_ff        <= '0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      rem_ff      <= rem_in;
      bad_ff      <= bad_in;
      src_ok_ff   <= src_ok_in;
      fwd_ff      <= fwd_in;
      fwd_byte_ff <= fwd_byte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         history[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= history[mem_ra];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_bad    = rsp_bad_ff;

endmodule

>>> design/lz77_history_copy_core.sv
// Top level of the LZ77 history copy core: register port, front end, queue, back end.
//
// Usage: tokens enter on the req_ stream. req_tuser carries the kind (literal,
// copy, restart); req_tdata carries literal, distance and run length. Decoded
// bytes leave on the rsp_ stream, one byte per transfer, with rsp_tlast on the
// final byte of each token and rsp_tuser set when a copy distance was out of
// range (the byte is then zero). The window limit sits at address 0 of the csr_ port.
// Throughput: a copy first issues the read of its first byte on the single read
// port of the history memory, then emits one byte per cycle while the receiver
// takes them; a restart emits nothing. A literal goes from the token queue
// straight to the output register, a copy by way of that read. A four-entry
// token queue lets the front end keep accepting while the back end works. When
// the receiver holds rsp_tready low the output register holds its byte, the
// back end stalls and the queue fills, then req_tready falls. Reset empties the
// queue, clears the write position and fill count and sets the window limit to
// 8192; the history needs no clearing, as bytes before the last restart read as zero.
module lz77_history_copy_core #(
   parameter int WINDOW_DEPTH = 8192,
   parameter int MAX_RUN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [31:0]                   req_tdata,  // literal[7:0], distance[21:8], run_length[28:22]
   input  logic [lz77hc_pkg::KIND_W-1:0] req_tuser,  // kind[1:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,  // out_byte[7:0]
   output logic                          rsp_tlast,
   output logic                          rsp_tuser,  // bad_distance[0]
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic [lz77hc_pkg::WSIZE_W-1:0] win_limit_ff, win_limit_in;
   logic                           csr_write;
   logic                           q_push;
   logic                           q_pop;
   logic                           q_full;
   logic                           q_not_empty;
   lz77hc_pkg::token_type          q_token;
   lz77hc_pkg::token_type          q_head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == lz77hc_pkg::REG_WINDOW_SIZE);
   assign win_limit_in = csr_write ? csr_pwdata[lz77hc_pkg::WSIZE_W-1:0] : win_limit_ff;
   assign csr_prdata = (csr_paddr[2] == lz77hc_pkg::REG_WINDOW_SIZE) ?
                       {{(32 - lz77hc_pkg::WSIZE_W){1'b0}}, win_limit_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_limit_ff <= lz77hc_pkg::WSIZE_RESET;
      end else begin
         win_limit_ff <= win_limit_in;
      end
   end

   lz77hc_front #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .MAX_RUN      (MAX_RUN)
   ) u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .win_limit   (win_limit_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_token     (q_token)
   );

   lz77hc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_token),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   lz77hc_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_byte    (rsp_tdata),
      .rsp_last    (rsp_tlast),
      .rsp_bad     (rsp_tuser)
   );

endmodule
